// File: rtl/dfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants of the dipole field sum block
// Field widths, fixed-point shifts, register indexes, handshake structs of
// the iterative arithmetic units and the state encoding of the sequencer.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int unsigned MAX_SITES_DEF = 256;

    // Item and register field widths.
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned SPIN_W     = 16;
    localparam int unsigned FIELD_W    = 32;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned STR_W      = 24;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;

    // Datapath widths. Positions are Q.6, so r^2 is Q.12 and fits 34 bits.
    localparam int unsigned DIFF_W = 17;
    localparam int unsigned R2_W   = 34;
    localparam int unsigned DOT_W  = 34;
    localparam int unsigned DOT3_W = 36;
    localparam int unsigned T1_W   = 53;
    localparam int unsigned R2S_W  = 51;
    localparam int unsigned NUM_W  = 54;
    localparam int unsigned MAG_W  = 53;

    // Divider and root unit widths.
    localparam int unsigned SHIFT_1   = 26;
    localparam int unsigned SHIFT_2   = 12;
    localparam int unsigned SHIFT_3   = 6;
    localparam int unsigned DVD_W     = MAG_W + SHIFT_1;
    localparam int unsigned DVS_W     = R2_W;
    localparam int unsigned QUO_W     = 64;
    localparam int unsigned RAD_SHIFT = 16;
    localparam int unsigned RAD_W     = R2_W + RAD_SHIFT;
    localparam int unsigned ROOT_W    = RAD_W / 2;

    // Accumulation and final scaling.
    localparam int unsigned SUM_W       = 64;
    localparam int unsigned CHUNK_W     = 16;
    localparam int unsigned SCALE_STEPS = SUM_W / CHUNK_W;
    localparam int unsigned SCALE_K_W   = $clog2(SCALE_STEPS);
    localparam int unsigned PROD_W      = SUM_W + STR_W;
    localparam int unsigned PP_W        = CHUNK_W + STR_W;

    // Sources with r^2 below 0.1 (409.6 in Q.12) are skipped.
    localparam logic [R2_W-1:0] SKIP_R2 = R2_W'(410);

    localparam logic [CNT_W-1:0] COUNT_RESET    = CNT_W'(1);
    localparam logic [STR_W-1:0] STRENGTH_RESET = STR_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH   = CFG_IDX_W'(1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] STAGE_FIRST = 2'd0;
    localparam logic [1:0] STAGE_LAST  = 2'd2;
    localparam logic [SCALE_K_W-1:0] K_LAST = SCALE_K_W'(SCALE_STEPS - 1);

    localparam int unsigned ENTRY_W = 2 * POS_W + 2 * SPIN_W;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [SPIN_W-1:0] spin_x;
        logic signed [SPIN_W-1:0] spin_y;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_DIFF,
        ST_MUL1,
        ST_SUMS,
        ST_CHECK,
        ST_MUL2,
        ST_NUM,
        ST_ROOT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_NEXT,
        ST_SCALE,
        ST_OUT
    } state_t;

endpackage

// File: rtl/dfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_if: valid/ready channels of the dipole field sum block
// One interface carries load and query beats in, the other field results out.
// ----------------------------------------------------------------------------
interface dfs_in_if;
    import dfs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [IDX_W-1:0]         site_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [SPIN_W-1:0] spin_x;
    logic signed [SPIN_W-1:0] spin_y;

    modport source (
        output valid, kind, site_index, pos_x, pos_y, spin_x, spin_y,
        input  ready
    );

    modport sink (
        input  valid, kind, site_index, pos_x, pos_y, spin_x, spin_y,
        output ready
    );
endinterface

interface dfs_out_if;
    import dfs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;

    modport source (
        output valid, field_x, field_y,
        input  ready
    );

    modport sink (
        input  valid, field_x, field_y,
        output ready
    );
endinterface

// File: rtl/dfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/dfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_div: radix-2 restoring divider
// Produces one quotient bit per cycle; the quotient holds after busy falls.
// ----------------------------------------------------------------------------
module dfs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  dfs_pkg::div_req_t  req,
    output dfs_pkg::div_rsp_t  rsp
);
    import dfs_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(DVD_W);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [DVS_W:0]      trial;
    logic                fits;

    // The remainder stays below the divisor, so one extra bit holds the shift.
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DVD_W - 1);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;
endmodule

// File: rtl/dfs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_sqrt: digit-by-digit integer square root
// Retires two radicand bits and one root bit per cycle (floor of the root).
// ----------------------------------------------------------------------------
module dfs_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  dfs_pkg::sqrt_req_t req,
    output dfs_pkg::sqrt_rsp_t rsp
);
    import dfs_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(ROOT_W);
    localparam int unsigned REM_W    = ROOT_W + 2;
    localparam int unsigned CUR_W    = ROOT_W + 4;

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CUR_W-1:0]    cur;
    logic [CUR_W-1:0]    trial;
    logic                fits;

    assign cur   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = cur >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(ROOT_W - 1);
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? REM_W'(cur - trial) : REM_W'(cur);
            root_next = {root_reg[ROOT_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.root = root_reg;
endmodule

// File: rtl/dipole_field_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipole_field_sum: direct sum of 2-D point-dipole fields over a site table
// Holds a table of dipoles in a RAM and answers field queries by walking it.
// ----------------------------------------------------------------------------
// A load beat writes one table entry and produces no result; a load whose
// index lies beyond the table is dropped. A query beat walks the first
// min(site_count, MAX_SITES) entries, one at a time, and returns one
// result beat with the summed field scaled by dipole_strength and saturated
// to Q16.16. An entry closer than r^2 < 0.1 is skipped. Every other entry
// takes one square root, overlapped with the numerator multiplies, and six
// 79-bit divisions in a single shared radix-2 divider. Table entries must
// be loaded before a query reads them. A new beat is taken as soon as the
// block is back in idle, even while the last result still waits in the
// output register.
// ----------------------------------------------------------------------------
module dipole_field_sum #(
    parameter int unsigned MAX_SITES = dfs_pkg::MAX_SITES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    dfs_in_if.sink                         item,
    dfs_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dfs_pkg::*;

    localparam int unsigned AW = $clog2(MAX_SITES);
    localparam int unsigned CW = $clog2(MAX_SITES + 1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] site_count_reg;
    logic [STR_W-1:0] strength_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg <= COUNT_RESET;
            strength_reg   <= STRENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SITE_COUNT: site_count_reg <= cfg_data[CNT_W-1:0];
                REG_STRENGTH:   strength_reg   <= cfg_data[STR_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and the site table.
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic   accept;
    logic   is_query;
    logic   ram_we;
    entry_t wr_entry;
    entry_t rd_entry;
    logic [CW-1:0] limit;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] j_reg, j_next;

    assign accept   = item.valid && item.ready;
    assign is_query = item.kind == KIND_QUERY;
    assign ram_we   = accept && !is_query && (32'(item.site_index) < MAX_SITES);
    assign limit    = (32'(site_count_reg) < MAX_SITES) ? CW'(site_count_reg)
                                                        : CW'(MAX_SITES);

    assign wr_entry.pos_x  = item.pos_x;
    assign wr_entry.pos_y  = item.pos_y;
    assign wr_entry.spin_x = item.spin_x;
    assign wr_entry.spin_y = item.spin_y;

    dfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SITES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.site_index)),
        .wdata (wr_entry),
        .raddr (j_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    // ------------------------------------------------------------------
    // Per-entry datapath: differences, squares, dot product, numerators.
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]  ox_reg, oy_reg;
    logic signed [DIFF_W-1:0] rx_reg, ry_reg, rx_next, ry_next;
    logic signed [SPIN_W-1:0] sx_reg, sy_reg;
    logic signed [R2_W-1:0]   rx2_reg, ry2_reg, rx2_next, ry2_next;
    logic signed [DOT_W-1:0]  pxs_reg, pys_reg, pxs_next, pys_next;
    logic [R2_W-1:0]          r2_reg, r2_next;
    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT3_W-1:0] dot3_reg, dot3_next;
    logic signed [T1_W-1:0]   t1x_reg, t1y_reg, t1x_next, t1y_next;
    logic signed [R2S_W-1:0]  r2sx_reg, r2sy_reg, r2sx_next, r2sy_next;
    logic signed [NUM_W-1:0]  numx, numy, negnumx, negnumy;
    logic [MAG_W-1:0]         magx_reg, magy_reg, magx_next, magy_next;
    logic                     negx_reg, negy_reg;

    assign rx_next  = DIFF_W'(ox_reg) - DIFF_W'(rd_entry.pos_x);
    assign ry_next  = DIFF_W'(oy_reg) - DIFF_W'(rd_entry.pos_y);
    assign rx2_next = rx_reg * rx_reg;
    assign ry2_next = ry_reg * ry_reg;
    assign pxs_next = rx_reg * sx_reg;
    assign pys_next = ry_reg * sy_reg;
    assign r2_next  = R2_W'(rx2_reg + ry2_reg);
    assign dot      = pxs_reg + pys_reg;
    assign dot3_next = (DOT3_W'(dot) <<< 1) + DOT3_W'(dot);
    assign t1x_next  = dot3_reg * rx_reg;
    assign t1y_next  = dot3_reg * ry_reg;
    assign r2sx_next = $signed({1'b0, r2_reg}) * sx_reg;
    assign r2sy_next = $signed({1'b0, r2_reg}) * sy_reg;
    assign numx      = t1x_reg - r2sx_reg;
    assign numy      = t1y_reg - r2sy_reg;
    assign negnumx   = -numx;
    assign negnumy   = -numy;
    assign magx_next = numx[NUM_W-1] ? negnumx[MAG_W-1:0] : numx[MAG_W-1:0];
    assign magy_next = numy[NUM_W-1] ? negnumy[MAG_W-1:0] : numy[MAG_W-1:0];

    // ------------------------------------------------------------------
    // Shared arithmetic units. Each component goes through three truncating
    // divisions: by r^2 (shift 26), by r^2 (shift 12), then by the Q.14
    // root of r^2 (shift 6), leaving a Q.32 term.
    // ------------------------------------------------------------------
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    logic [1:0]       stage_reg, stage_next;
    logic             comp_reg, comp_next;
    logic [QUO_W-1:0] q_reg;
    logic [MAG_W-1:0] mag_sel;
    logic             neg_sel;
    logic signed [SUM_W-1:0] term;

    assign mag_sel = comp_reg ? magy_reg : magx_reg;
    assign neg_sel = comp_reg ? negy_reg : negx_reg;
    assign term    = neg_sel ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);

    always_comb
    begin
        div_req.start = state_reg == ST_DIV_GO;
        unique case (stage_reg)
            STAGE_FIRST:
            begin
                div_req.dividend = {mag_sel, {SHIFT_1{1'b0}}};
                div_req.divisor  = r2_reg;
            end
            STAGE_LAST:
            begin
                div_req.dividend = DVD_W'({q_reg, {SHIFT_3{1'b0}}});
                div_req.divisor  = DVS_W'(sqrt_rsp.root);
            end
            default:
            begin
                div_req.dividend = DVD_W'({q_reg, {SHIFT_2{1'b0}}});
                div_req.divisor  = r2_reg;
            end
        endcase
    end

    dfs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    dfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Final scaling: |sum| * strength >> 32, built from four 16-bit chunks.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [SUM_W-1:0]        abs_x, abs_y;
    logic [CHUNK_W-1:0]      chunk_x, chunk_y;
    logic [PP_W-1:0]         pp_x, pp_y;
    logic [PROD_W-1:0]       prod_x_reg, prod_y_reg, prod_x_next, prod_y_next;
    logic [SCALE_K_W-1:0]    k_reg, k_next;
    logic [5:0]              chunk_shift;

    assign abs_x       = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign abs_y       = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign chunk_shift = {k_reg, 4'b0000};
    assign chunk_x     = abs_x[chunk_shift +: CHUNK_W];
    assign chunk_y     = abs_y[chunk_shift +: CHUNK_W];
    assign pp_x        = chunk_x * strength_reg;
    assign pp_y        = chunk_y * strength_reg;
    assign prod_x_next = prod_x_reg + (PROD_W'(pp_x) << chunk_shift);
    assign prod_y_next = prod_y_reg + (PROD_W'(pp_y) << chunk_shift);

    function automatic logic [FIELD_W-1:0] saturate(
        input logic             neg,
        input logic [PROD_W-1:0] prod
    );
        logic [PROD_W-33:0] p;
        logic [FIELD_W-1:0] res;
        p = prod[PROD_W-1:32];
        if (neg)
        begin
            res = (p >= (PROD_W-32)'(32'h8000_0000)) ? 32'h8000_0000
                                                    : FIELD_W'(-p);
        end
        else
        begin
            res = (p > (PROD_W-32)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                   : p[FIELD_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic out_free;
    logic signed [FIELD_W-1:0] field_x_reg, field_y_reg;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = (limit == '0) ? ST_SCALE : ST_RD;
                end
            end
            ST_RD:    state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_SUMS;
            ST_SUMS:  state_next = ST_CHECK;
            ST_CHECK: state_next = (r2_reg < SKIP_R2) ? ST_NEXT : ST_MUL2;
            ST_MUL2:  state_next = ST_NUM;
            ST_NUM:   state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (!sqrt_rsp.busy)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!div_rsp.busy)
                begin
                    state_next = (stage_reg != STAGE_LAST || !comp_reg) ? ST_DIV_GO
                                                                        : ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                state_next = (CW'(j_reg + 1'b1) == n_reg) ? ST_SCALE : ST_RD;
            end
            ST_SCALE:
            begin
                if (k_reg == K_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and root unit request.
    always_comb
    begin
        item.ready        = state_reg == ST_IDLE;
        sqrt_req.start    = (state_reg == ST_CHECK) && !(r2_reg < SKIP_R2);
        sqrt_req.radicand = {r2_reg, {RAD_SHIFT{1'b0}}};
    end

    // Counters of the walk and of the division chain.
    always_comb
    begin
        n_next     = n_reg;
        j_next     = j_reg;
        stage_next = stage_reg;
        comp_next  = comp_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    n_next = limit;
                    j_next = '0;
                    k_next = '0;
                end
            end
            ST_ROOT:
            begin
                stage_next = STAGE_FIRST;
                comp_next  = 1'b0;
            end
            ST_DIV_WAIT:
            begin
                if (!div_rsp.busy)
                begin
                    if (stage_reg != STAGE_LAST)
                    begin
                        stage_next = stage_reg + 1'b1;
                    end
                    else
                    begin
                        stage_next = STAGE_FIRST;
                        comp_next  = 1'b1;
                    end
                end
            end
            ST_NEXT:  j_next = CW'(j_reg + 1'b1);
            ST_SCALE: k_next = k_reg + 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            j_reg         <= '0;
            stage_reg     <= STAGE_FIRST;
            comp_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            j_reg     <= j_next;
            stage_reg <= stage_next;
            comp_reg  <= comp_next;
            k_reg     <= k_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, loaded by state.
    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            ox_reg     <= item.pos_x;
            oy_reg     <= item.pos_y;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            prod_x_reg <= '0;
            prod_y_reg <= '0;
        end
        if (state_reg == ST_DIFF)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            sx_reg <= rd_entry.spin_x;
            sy_reg <= rd_entry.spin_y;
        end
        if (state_reg == ST_MUL1)
        begin
            rx2_reg <= rx2_next;
            ry2_reg <= ry2_next;
            pxs_reg <= pxs_next;
            pys_reg <= pys_next;
        end
        if (state_reg == ST_SUMS)
        begin
            r2_reg   <= r2_next;
            dot3_reg <= dot3_next;
        end
        if (state_reg == ST_MUL2)
        begin
            t1x_reg  <= t1x_next;
            t1y_reg  <= t1y_next;
            r2sx_reg <= r2sx_next;
            r2sy_reg <= r2sy_next;
        end
        if (state_reg == ST_NUM)
        begin
            magx_reg <= magx_next;
            magy_reg <= magy_next;
            negx_reg <= numx[NUM_W-1];
            negy_reg <= numy[NUM_W-1];
        end
        if (state_reg == ST_DIV_WAIT && !div_rsp.busy)
        begin
            q_reg <= div_rsp.quotient;
            if (stage_reg == STAGE_LAST)
            begin
                if (comp_reg)
                begin
                    sum_y_reg <= sum_y_reg + term;
                end
                else
                begin
                    sum_x_reg <= sum_x_reg + term;
                end
            end
        end
        if (state_reg == ST_SCALE)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            field_x_reg <= saturate(sum_x_reg[SUM_W-1], prod_x_reg);
            field_y_reg <= saturate(sum_y_reg[SUM_W-1], prod_y_reg);
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.field_x = field_x_reg;
    assign result.field_y = field_y_reg;

`ifndef ASSERT_OFF
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> j_reg < n_reg)
        else $error("table walk reads past the entry count");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_root_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_GO && stage_reg == STAGE_LAST |-> !sqrt_rsp.busy)
        else $error("root used before it is complete");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_OUT))
        else $error("result beat raised outside the output state");
`endif
endmodule

// File: dv/dipole_field_sum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipole_field_sum_tb: self-checking bench of the dipole field sum block
// Loads dipole tables, reprograms site count and strength between phases and
// fires field queries under random source gaps and sink stalls. A bit-exact
// fixed-point predictor computes every field beat, and each result beat is
// compared in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
module dipole_field_sum_tb;
    import dfs_pkg::*;

    typedef struct {
        logic signed [FIELD_W-1:0] fx;
        logic signed [FIELD_W-1:0] fy;
    } field_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dfs_in_if  in_ch ();
    dfs_out_if out_ch ();

    dipole_field_sum DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch.sink),
        .result    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow of the block: its table, its registers, and which entries have
    // been loaded so that a query never walks an entry that was never written.
    logic signed [POS_W-1:0]  site_px [MAX_SITES_DEF];
    logic signed [POS_W-1:0]  site_py [MAX_SITES_DEF];
    logic signed [SPIN_W-1:0] site_sx [MAX_SITES_DEF];
    logic signed [SPIN_W-1:0] site_sy [MAX_SITES_DEF];
    bit                       loaded  [MAX_SITES_DEF];
    bit [63:0] count_reg = 64'(COUNT_RESET);
    bit [63:0] strength_reg = 64'(STRENGTH_RESET);

    field_t pending_fields[$];
    int errors = 0;
    bit quiet = 1'b0;   // no gaps and no stalls from the last phase of the first random run on

    // Integer square root, bit by bit, floor result.
    function automatic bit [63:0] root_floor(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // floor(n * 2^sh / d), in the same 64-bit wrap as the hardware intends.
    function automatic bit [63:0] frac_div(bit [63:0] n, bit [63:0] d, int sh);
        bit [63:0] q;
        bit [63:0] rem;
        q = n / d;
        rem = n % d;
        return (q << sh) + ((rem << sh) / d);
    endfunction

    // One field component of one source: |num| / r2 / r2 / r, sign restored.
    function automatic longint dipole_term(longint num, bit [63:0] r2, bit [63:0] r14);
        bit [63:0] mag;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        mag = frac_div(mag, r2, SHIFT_1);
        mag = frac_div(mag, r2, SHIFT_2);
        mag = frac_div(mag, r14, SHIFT_3);
        return (num < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Strength scaling of a Q.32 sum down to a saturated Q16.16 field.
    function automatic logic signed [FIELD_W-1:0] scaled_field(longint total);
        bit [63:0] m;
        bit [63:0] p;
        m = (total < 0) ? 64'(-total) : 64'(total);
        p = ((m >> 16) * strength_reg + (((m & 64'hFFFF) * strength_reg) >> 16)) >> 16;
        if (total < 0)
            return (p >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - p);
        return (p > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(p);
    endfunction

    // Field at the observer, summed over the active part of the table.
    function automatic field_t field_at(logic signed [POS_W-1:0] ox,
                                        logic signed [POS_W-1:0] oy);
        field_t f;
        longint sum_x;
        longint sum_y;
        longint rx;
        longint ry;
        longint dot;
        bit [63:0] r2;
        bit [63:0] r14;
        int n;
        sum_x = 0;
        sum_y = 0;
        n = (count_reg < MAX_SITES_DEF) ? int'(count_reg) : MAX_SITES_DEF;
        for (int j = 0; j < n; j++) begin
            rx = longint'(ox) - longint'(site_px[j]);
            ry = longint'(oy) - longint'(site_py[j]);
            r2 = 64'(rx * rx + ry * ry);
            // Sources inside r^2 < 0.1 are the self-term and are skipped.
            if (r2 < 64'(SKIP_R2))
                continue;
            r14 = root_floor(r2 << RAD_SHIFT);
            dot = rx * longint'(site_sx[j]) + ry * longint'(site_sy[j]);
            sum_x += dipole_term(3 * dot * rx - longint'(r2) * longint'(site_sx[j]), r2, r14);
            sum_y += dipole_term(3 * dot * ry - longint'(r2) * longint'(site_sy[j]), r2, r14);
        end
        f.fx = scaled_field(sum_x);
        f.fy = scaled_field(sum_y);
        return f;
    endfunction

    // Sends one beat, with an optional idle burst first, and updates the
    // shadow state at the edge where the beat is taken.
    task automatic send_beat(logic kind, logic [IDX_W-1:0] idx,
                             logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                             logic signed [SPIN_W-1:0] sx, logic signed [SPIN_W-1:0] sy);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.site_index <= idx;
        in_ch.pos_x      <= px;
        in_ch.pos_y      <= py;
        in_ch.spin_x     <= sx;
        in_ch.spin_y     <= sy;
        forever begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        if (kind == KIND_LOAD) begin
            site_px[idx] = px;
            site_py[idx] = py;
            site_sx[idx] = sx;
            site_sy[idx] = sy;
            loaded[idx] = 1'b1;
        end
        else
            pending_fields.push_back(field_at(px, py));
    endtask

    task automatic load_site(int idx, int px, int py, int sx, int sy);
        send_beat(KIND_LOAD, IDX_W'(idx), POS_W'(px), POS_W'(py), SPIN_W'(sx), SPIN_W'(sy));
    endtask

    task automatic query_at(int px, int py);
        send_beat(KIND_QUERY, IDX_W'($urandom), POS_W'(px), POS_W'(py),
                  SPIN_W'($urandom), SPIN_W'($urandom));
    endtask

    // Stops the source, waits for every outstanding field beat, then lets
    // the block settle so that a register write lands while it is idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SITE_COUNT)
            count_reg = 64'(data) & 64'h1FF;
        else
            strength_reg = 64'(data) & 64'hFF_FFFF;
    endtask

    // Hand-picked cases: a unit dipole at unit distance, the skip boundary,
    // extreme positions and spins, zero count, zero and full strength, and a
    // close source strong enough to saturate both components.
    task automatic test_directed();
        load_site(0, 0, 0, 16384, 0);
        query_at(64, 0);
        query_at(0, 64);
        query_at(0, 0);            // observer on the source itself
        query_at(20, 0);           // r^2 = 400, just inside the skip radius
        query_at(21, 0);           // r^2 = 441, just outside it
        load_site(1, -32768, -32768, -32768, 32767);
        drain();
        write_reg(REG_SITE_COUNT, 24'd2);
        query_at(32767, 32767);
        query_at(-32768, 32767);
        query_at(-32700, -32768);
        drain();
        write_reg(REG_SITE_COUNT, 24'd0);
        query_at(64, 64);          // nothing summed
        drain();
        write_reg(REG_STRENGTH, 24'd0);
        write_reg(REG_SITE_COUNT, 24'd2);
        query_at(64, 0);
        drain();
        write_reg(REG_STRENGTH, 24'hFF_FFFF);
        load_site(0, 0, 0, 32767, -32768);
        load_site(1, 21, 0, 32767, 32767);
        query_at(0, 21);
        query_at(10, -20);
        query_at(-21, 0);
        // Upper data bits beyond the register width are dropped.
        drain();
        write_reg(REG_SITE_COUNT, 24'hFF_FE01);
        query_at(100, -100);
    endtask

    // The whole table, then a walk over all of it and one with the count
    // programmed beyond the table size.
    task automatic test_full_table();
        drain();
        write_reg(REG_STRENGTH, 24'($urandom_range(1, 24'hFF_FFFF)));
        for (int j = 0; j < MAX_SITES_DEF; j++)
            load_site(j, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                      $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        query_at(0, 0);
        drain();
        write_reg(REG_SITE_COUNT, 24'd256);
        query_at(int'(site_px[7]), int'(site_py[7]));
        drain();
        write_reg(REG_SITE_COUNT, 24'h00_01FF);
        query_at($urandom, $urandom);
    endtask

    // Random phases with small site counts. Loads mostly target the low
    // entries that queries read; observers often sit near a source so that
    // both the skip and the strong near field are exercised.
    task automatic test_random(int phases, int beats);
        int cnt;
        int j;
        int px;
        int py;
        for (int ph = 0; ph < phases; ph++) begin
            drain();
            if (ph == phases - 1)
                quiet = 1'b1;
            cnt = $urandom_range(1, 4);
            write_reg(REG_SITE_COUNT, 24'(cnt));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_STRENGTH, 24'hFF_FFFF);
                1:       write_reg(REG_STRENGTH, 24'(65536 >> $urandom_range(0, 8)));
                default: write_reg(REG_STRENGTH, 24'($urandom));
            endcase
            for (int k = 0; k < beats; k++) begin
                if ($urandom_range(0, 99) < 65) begin
                    j = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
                    if ($urandom_range(0, 1) != 0) begin
                        px = $urandom_range(0, 1023) - 512;
                        py = $urandom_range(0, 1023) - 512;
                    end
                    else begin
                        px = $urandom;
                        py = $urandom;
                    end
                    if ($urandom_range(0, 4) == 0)
                        load_site(j, px, py, $urandom, $urandom);
                    else
                        load_site(j, px, py, $urandom_range(0, 32768) - 16384,
                                  $urandom_range(0, 32768) - 16384);
                end
                else begin
                    j = 0;
                    for (int e = 0; e < cnt; e++)
                        if (!loaded[e])
                            j = -1;
                    if (j < 0)
                        continue;
                    case ($urandom_range(0, 3))
                        0, 1: begin
                            j = $urandom_range(0, cnt - 1);
                            query_at(int'(site_px[j]) + $urandom_range(0, 48) - 24,
                                     int'(site_py[j]) + $urandom_range(0, 48) - 24);
                        end
                        2:       query_at($urandom_range(0, 2047) - 1024,
                                          $urandom_range(0, 2047) - 1024);
                        default: query_at($urandom, $urandom);
                    endcase
                end
            end
        end
    endtask

    // Result sink: random stall bursts on ready, and an in-order check of
    // every field beat against the oldest prediction.
    int stall_left = 0;
    field_t want;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_fields.size() == 0) begin
                    errors++;
                    $display("%0t: field beat with nothing expected: x=%0d y=%0d",
                             $time, out_ch.field_x, out_ch.field_y);
                end
                else begin
                    want = pending_fields.pop_front();
                    if (out_ch.field_x !== want.fx) begin
                        errors++;
                        $display("%0t: field_x expected %0d actual %0d",
                                 $time, want.fx, out_ch.field_x);
                    end
                    if (out_ch.field_y !== want.fy) begin
                        errors++;
                        $display("%0t: field_y expected %0d actual %0d",
                                 $time, want.fy, out_ch.field_y);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(0, 17);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_LOAD;
        in_ch.site_index = '0;
        in_ch.pos_x      = '0;
        in_ch.pos_y      = '0;
        in_ch.spin_x     = '0;
        in_ch.spin_y     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(6, 100);
        test_full_table();
        test_random(8, 100);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_fields.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Generous ceiling: two full-table walks plus every small query at its
    // slowest, with room for all the stalls and gaps.
    initial begin
        #200ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
